FILE: rtl/lwdt_pkg.sv
package lwdt_pkg;

  // build-time sizing
  localparam int MAX_SAMPLES = 4096;
  localparam int RANGE_BITS  = 16;

  localparam int RNG_W    = (RANGE_BITS < 16) ? RANGE_BITS : 16;
  localparam int IDX_W    = $clog2(MAX_SAMPLES);
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W    = RNG_W + IDX_W;
  localparam int PROD_W   = SUM_W + CNT_W;
  localparam int ASTEP_W  = 12;
  localparam int APROD_W  = IDX_W + ASTEP_W;
  localparam int ANG_W    = (APROD_W + 2 > 20) ? APROD_W + 2 : 20;
  localparam int STEP_W   = $clog2(RNG_W + 1);
  localparam int FIN_LAST = RNG_W;

  // quarter turn in 2^-16 rad
  localparam int QUARTER_TURN = 102944;

  // window lanes
  localparam int NUM_WIN = 6;
  localparam int WIN_L   = 0;
  localparam int WIN_R   = 1;
  localparam int WIN_LF  = 2;
  localparam int WIN_LB  = 3;
  localparam int WIN_RF  = 4;
  localparam int WIN_RB  = 5;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ANGLE = 3'd0,
    CFG_ANGLE_STEP  = 3'd1,
    CFG_SIDE_HALF   = 3'd2,
    CFG_TILT_HALF   = 3'd3,
    CFG_TILT_OFFSET = 3'd4
  } cfg_idx_t;

  localparam int FIRST_ANGLE_RST = -205888;
  localparam int ANGLE_STEP_RST  = 1144;
  localparam int SIDE_HALF_RST   = 1144;
  localparam int TILT_HALF_RST   = 2288;
  localparam int TILT_OFFSET_RST = 17157;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        range_finite;
    logic        last_sample;
  } sample_t;

  typedef struct packed {
    logic [15:0] left_mm;
    logic        left_valid;
    logic [15:0] right_mm;
    logic        right_valid;
    logic        facing_sign;
    logic        sign_updated;
    logic        scan_overflow;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic              take;
    logic              acc;
    logic              fin;
    logic              load;
    logic [STEP_W-1:0] step;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } dp_sts_t;

  // datapath to divider
  typedef struct packed {
    logic start;
    logic step;
  } div_cmd_t;

endpackage

FILE: rtl/lwdt_div.sv
module lwdt_div import lwdt_pkg::*; (
  input  logic             clk,
  input  div_cmd_t         cmd,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [RNG_W-1:0] quot
);

  // restoring divider, one quotient bit per step; quotient known to fit RNG_W
  logic [CNT_W-1:0] rem;
  logic [RNG_W-1:0] q;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, q[RNG_W-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= CNT_W'(dividend[SUM_W-1:RNG_W]);
      q   <= dividend[RNG_W-1:0];
    end else if (cmd.step) begin
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      q   <= {q[RNG_W-2:0], ge};
    end
  end

  assign quot = q;

endmodule

FILE: rtl/lwdt_dp.sv
module lwdt_dp import lwdt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  input  sample_t               sample,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output dp_sts_t               sts,
  output result_t               result
);

  // configuration
  logic signed [19:0] first_angle;
  logic [ASTEP_W-1:0] angle_step;
  logic [15:0]        side_half;
  logic [15:0]        tilt_half;
  logic [15:0]        tilt_offset;

  // per-scan state
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [SUM_W-1:0] sums   [NUM_WIN];
  logic [CNT_W-1:0] counts [NUM_WIN];
  logic             held_sign;

  // captured sample
  logic [RNG_W-1:0]   rng_q;
  logic               fin_q;
  logic               last_q;
  logic               do_acc;
  logic [APROD_W-1:0] aprod;

  // end-of-scan compare
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] first_p;
  logic              lt_lr;
  logic              lt_lfb;
  logic              lt_rfb;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_angle <= 20'(FIRST_ANGLE_RST);
      angle_step  <= ASTEP_W'(ANGLE_STEP_RST);
      side_half   <= 16'(SIDE_HALF_RST);
      tilt_half   <= 16'(TILT_HALF_RST);
      tilt_offset <= 16'(TILT_OFFSET_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FIRST_ANGLE: first_angle <= cfg_data[19:0];
        CFG_ANGLE_STEP:  angle_step  <= cfg_data[ASTEP_W-1:0];
        CFG_SIDE_HALF:   side_half   <= cfg_data[15:0];
        CFG_TILT_HALF:   tilt_half   <= cfg_data[15:0];
        CFG_TILT_OFFSET: tilt_offset <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sample angle and window test
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W-1:0] quarter;
  logic signed [ANG_W-1:0] off_s;
  logic signed [ANG_W-1:0] ctr    [NUM_WIN];
  logic signed [ANG_W-1:0] half_s [NUM_WIN];
  logic signed [ANG_W-1:0] lo     [NUM_WIN];
  logic signed [ANG_W-1:0] hi     [NUM_WIN];
  logic [NUM_WIN-1:0]      hit;

  always_comb begin
    ang     = ANG_W'(first_angle) + ANG_W'(aprod);
    quarter = ANG_W'(QUARTER_TURN);
    off_s   = ANG_W'(tilt_offset);
    ctr[WIN_L]  = quarter;
    ctr[WIN_R]  = -quarter;
    ctr[WIN_LF] = quarter - off_s;
    ctr[WIN_LB] = quarter + off_s;
    ctr[WIN_RF] = off_s - quarter;
    ctr[WIN_RB] = -quarter - off_s;
    for (int k = 0; k < NUM_WIN; k++) begin
      half_s[k] = (k == WIN_L || k == WIN_R) ? ANG_W'(side_half) : ANG_W'(tilt_half);
      lo[k]     = ctr[k] - half_s[k];
      hi[k]     = ctr[k] + half_s[k];
      hit[k]    = (ang > lo[k]) && (ang < hi[k]);
    end
  end

  // shared multiplier operand select
  logic [SUM_W-1:0] mul_a;
  logic [CNT_W-1:0] mul_b;

  always_comb begin
    case (cmd.step)
      STEP_W'(0): begin mul_a = sums[WIN_L];  mul_b = counts[WIN_R];  end
      STEP_W'(1): begin mul_a = sums[WIN_R];  mul_b = counts[WIN_L];  end
      STEP_W'(2): begin mul_a = sums[WIN_LF]; mul_b = counts[WIN_LB]; end
      STEP_W'(3): begin mul_a = sums[WIN_LB]; mul_b = counts[WIN_LF]; end
      STEP_W'(4): begin mul_a = sums[WIN_RF]; mul_b = counts[WIN_RB]; end
      STEP_W'(5): begin mul_a = sums[WIN_RB]; mul_b = counts[WIN_RF]; end
      default:    begin mul_a = '0;           mul_b = '0;             end
    endcase
  end

  // averages
  div_cmd_t         div_cmd;
  logic [RNG_W-1:0] quot_l;
  logic [RNG_W-1:0] quot_r;

  assign div_cmd.start = cmd.fin && (cmd.step == '0);
  assign div_cmd.step  = cmd.fin && (cmd.step != '0);

  lwdt_div u_div_l (
    .clk      (clk),
    .cmd      (div_cmd),
    .dividend (sums[WIN_L]),
    .divisor  (counts[WIN_L]),
    .quot     (quot_l)
  );

  lwdt_div u_div_r (
    .clk      (clk),
    .cmd      (div_cmd),
    .dividend (sums[WIN_R]),
    .divisor  (counts[WIN_R]),
    .quot     (quot_r)
  );

  // sign decision and result
  logic    v_l, v_r, v_lf, v_lb, v_rf, v_rb;
  logic    left_closer;
  logic    sign_next;
  logic    upd;
  result_t res_next;

  always_comb begin
    v_l  = counts[WIN_L]  != '0;
    v_r  = counts[WIN_R]  != '0;
    v_lf = counts[WIN_LF] != '0;
    v_lb = counts[WIN_LB] != '0;
    v_rf = counts[WIN_RF] != '0;
    v_rb = counts[WIN_RB] != '0;
    left_closer = v_l && (!v_r || lt_lr);
    sign_next   = held_sign;
    upd         = 1'b0;
    if (left_closer) begin
      if (v_lf && v_lb) begin
        sign_next = !lt_lfb;
        upd       = 1'b1;
      end
    end else if (v_rf && v_rb) begin
      sign_next = lt_rfb;
      upd       = 1'b1;
    end
    res_next.left_mm       = v_l ? 16'(quot_l) : 16'd0;
    res_next.left_valid    = v_l;
    res_next.right_mm      = v_r ? 16'(quot_r) : 16'd0;
    res_next.right_valid   = v_r;
    res_next.facing_sign   = sign_next;
    res_next.sign_updated  = upd;
    res_next.scan_overflow = ovf;
  end

  // accumulation and scan control
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      count <= '0;
      ovf   <= 1'b0;
      for (int k = 0; k < NUM_WIN; k++) begin
        sums[k]   <= '0;
        counts[k] <= '0;
      end
    end else begin
      if (cmd.take) begin
        if (count < CNT_W'(MAX_SAMPLES)) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.acc && do_acc && fin_q) begin
        for (int k = 0; k < NUM_WIN; k++) begin
          if (hit[k]) begin
            sums[k]   <= sums[k] + SUM_W'(rng_q);
            counts[k] <= counts[k] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_sign <= 1'b0;
    end else if (cmd.load) begin
      held_sign <= sign_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rng_q  <= sample.range_mm[RNG_W-1:0];
      fin_q  <= sample.range_finite;
      last_q <= sample.last_sample;
      do_acc <= count < CNT_W'(MAX_SAMPLES);
      aprod  <= APROD_W'(count[IDX_W-1:0]) * APROD_W'(angle_step);
    end
    if (cmd.fin) begin
      if (cmd.step < STEP_W'(6)) begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      case (cmd.step)
        STEP_W'(1): first_p <= prod;
        STEP_W'(2): lt_lr   <= first_p < prod;
        STEP_W'(3): first_p <= prod;
        STEP_W'(4): lt_lfb  <= first_p < prod;
        STEP_W'(5): first_p <= prod;
        STEP_W'(6): lt_rfb  <= first_p < prod;
        default: ;
      endcase
    end
    if (cmd.load) begin
      result <= res_next;
    end
  end

  assign sts.last = last_q;

endmodule

FILE: rtl/lwdt_ctrl.sv
module lwdt_ctrl import lwdt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_stall,
  output logic     result_valid,
  input  logic     result_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_FIN,
    S_LOAD
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              out_free;

  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = state != S_IDLE;

  always_comb begin
    cmd      = '0;
    cmd.step = step;
    case (state)
      S_IDLE:  cmd.take = sample_valid;
      S_ACC:   cmd.acc  = 1'b1;
      S_FIN:   cmd.fin  = 1'b1;
      S_LOAD:  cmd.load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) state <= S_ACC;
        end
        S_ACC: begin
          step <= '0;
          state <= sts.last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (step == STEP_W'(FIN_LAST)) begin
            state <= S_LOAD;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lidar_wall_distance_and_tilt_top.sv
// channel   direction  handshake                     payload
// sample    in         sample_valid / sample_stall   sample_t  (range_mm, range_finite, last_sample)
// result    out        result_valid / result_stall   result_t  (averages, flags, facing sign)
// config    in         cfg_write                     cfg_index, cfg_data (no read-back)
//
// a sample is transferred, then window-tested and accumulated
// a last sample then runs the serial averages and the cross products on the shared
// multiplier, then loads the result register
// rst is synchronous: config goes to its defaults, scan sums and the held sign clear
// a waiting result never blocks new samples; only the next scan end waits for
// result_stall to drop
module lidar_wall_distance_and_tilt_top import lwdt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // sample channel
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // config write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // command and status between the sequencer and the datapath
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer: handshakes, scan-end step count, output slot
  lwdt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // datapath: config, six window lanes, cross-product compare, two dividers
  lwdt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample    (sample),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .result    (result)
  );

endmodule

FILE: rtl/lwdt_checker.sv
module lwdt_checker import lwdt_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one sample at a time: a transfer is followed by a busy cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while previous one in progress");

  // empty windows report zero distance
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (!result.left_valid || !result.right_valid) |->
      (result.left_valid || result.left_mm == 16'd0) &&
      (result.right_valid || result.right_mm == 16'd0))
    else $error("empty window with nonzero distance");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind lidar_wall_distance_and_tilt_top lwdt_checker u_lwdt_checker (.*);
